>>> rtl/core/gbrb_pkg.sv
// ----------------------------------------------------------------------------
// gbrb_pkg: shared types and constants of the gated broadcast ring buffer
// Field widths, operation and status codes, and the command that the front
// hands to the back through the command queue.
// ----------------------------------------------------------------------------
package gbrb_pkg;

	// Storage geometry.
	localparam int RING_DEPTH    = 4096;
	localparam int SLOT_W        = $clog2(RING_DEPTH);
	localparam int MAX_CONSUMERS = 4;
	localparam int CONS_W        = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
	localparam int DATA_WIDTH    = 64;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths.
	localparam int OP_W      = 2;
	localparam int WHO_W     = 2;
	localparam int SEQ_W     = 48;
	localparam int PAYLOAD_W = 64;
	localparam int STATUS_W  = 2;
	localparam int STALL_W   = 32;
	localparam int CFG_N_W   = 3;
	localparam int ACT_W     = CFG_N_W + 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 3;

	localparam int IN_BITS     = OP_W + WHO_W + SEQ_W + PAYLOAD_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = STATUS_W + SEQ_W + PAYLOAD_W + STALL_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Sequence constants.
	localparam logic [SEQ_W-1:0] SEQ_MAX  = {1'b0, {(SEQ_W-1){1'b1}}};
	localparam logic [SEQ_W-1:0] SEQ_NONE = '1;
	localparam logic [SEQ_W-1:0] SEQ_DEPTH = SEQ_W'(RING_DEPTH);
	localparam logic [STALL_W-1:0] STALL_MAX = '1;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_COMMIT = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REFUSED   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_AVAIL = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CONSUMERS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAINED   = 1'd1;

	// Decoded command from the front.
	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [CONS_W-1:0]     who;
		logic [CONS_W-1:0]     prev;
		logic                  has_prev;
		logic [SEQ_W-1:0]      seq;
		logic [SLOT_W-1:0]     slot;
		logic [DATA_WIDTH-1:0] payload;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SEQ_W-1:0]     rseq;
		logic [PAYLOAD_W-1:0] data;
		logic [STALL_W-1:0]   stall;
	} res_t;

endpackage

>>> rtl/core/gbrb_front.sv
// ----------------------------------------------------------------------------
// gbrb_front: input stage of the gated broadcast ring buffer
// Takes input transactions, decodes them into commands and pushes them into
// the command queue.
// ----------------------------------------------------------------------------
module gbrb_front import gbrb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output logic                  push,
	output cmd_t                  push_cmd,
	input  logic                  q_full
);

	logic        fr_valid_q;
	cmd_t        fr_cmd_q;
	cmd_t        dec_cmd;
	logic [WHO_W-1:0] who_raw;

	// The slot index takes the low bits of the sequence; the ring depth is a
	// power of two.
	always_comb begin
		who_raw          = s_tdata[OP_W +: WHO_W];
		dec_cmd.op       = s_tdata[0 +: OP_W];
		dec_cmd.who      = CONS_W'(who_raw % MAX_CONSUMERS);
		dec_cmd.prev     = dec_cmd.who - CONS_W'(1);
		dec_cmd.has_prev = (dec_cmd.who != '0);
		dec_cmd.seq      = s_tdata[OP_W + WHO_W +: SEQ_W];
		dec_cmd.slot     = dec_cmd.seq[SLOT_W-1:0];
		dec_cmd.payload  = s_tdata[OP_W + WHO_W + SEQ_W +: DATA_WIDTH];
	end

	assign push     = fr_valid_q && !q_full;
	assign push_cmd = fr_cmd_q;
	assign s_tready = !fr_valid_q || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			fr_valid_q <= 1'b1;
		end else if (push) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			fr_cmd_q <= dec_cmd;
		end
	end

endmodule

>>> rtl/core/gbrb_queue.sv
// ----------------------------------------------------------------------------
// gbrb_queue: command queue between front and back
// A short first-in first-out buffer of decoded commands.
// ----------------------------------------------------------------------------
module gbrb_queue import gbrb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic q_valid,
	output cmd_t q_cmd,
	input  logic pop
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/core/gbrb_back.sv
// ----------------------------------------------------------------------------
// gbrb_back: execution side of the gated broadcast ring buffer
// Holds the ring memory, cursor, consumer positions, stall counter and
// configuration, carries out one command at a time and drives the result.
// ----------------------------------------------------------------------------
module gbrb_back import gbrb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 q_valid,
	input  cmd_t                 q_cmd,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0]            state_q;
	cmd_t                  cmd_q;
	logic [CONS_W-1:0]     idx_q;
	logic [SEQ_W-1:0]      gate_q;
	logic [SEQ_W-1:0]      cursor_q;
	logic [SEQ_W-1:0]      pos_q [MAX_CONSUMERS];
	logic [STALL_W-1:0]    stall_q;
	logic [CFG_N_W-1:0]    cons_in_use_q;
	logic                  chained_q;
	logic [DATA_WIDTH-1:0] ring_q [RING_DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  out_valid_q;
	res_t                  out_q;

	logic [ACT_W-1:0]      active_n;
	logic                  exec_fire;
	logic [SEQ_W-1:0]      next_seq;
	logic [SEQ_W-1:0]      wrap_seq;
	logic [SEQ_W-1:0]      avail;
	logic                  mem_we;
	logic                  cursor_we;
	logic                  stall_inc;
	logic                  pos_we;
	res_t                  res_n;

	// Out-of-range consumer counts are clamped into one to MAX_CONSUMERS.
	always_comb begin
		if (cons_in_use_q == '0) begin
			active_n = ACT_W'(1);
		end else if (ACT_W'(cons_in_use_q) > ACT_W'(MAX_CONSUMERS)) begin
			active_n = ACT_W'(MAX_CONSUMERS);
		end else begin
			active_n = ACT_W'(cons_in_use_q);
		end
	end

	assign pop       = (state_q == S_IDLE) && q_valid;
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || res_ready);
	assign next_seq  = cursor_q + SEQ_W'(1);
	assign wrap_seq  = next_seq - SEQ_DEPTH;
	assign avail     = (chained_q && cmd_q.has_prev) ? pos_q[cmd_q.prev] : cursor_q;

	always_comb begin
		res_n.status = STAT_DONE;
		res_n.rseq   = '0;
		res_n.data   = '0;
		res_n.stall  = stall_q;
		mem_we       = 1'b0;
		cursor_we    = 1'b0;
		stall_inc    = 1'b0;
		pos_we       = 1'b0;
		unique case (cmd_q.op)
			OP_WRITE: begin
				if (cursor_q == SEQ_MAX) begin
					res_n.status = STAT_REFUSED;
					res_n.rseq   = SEQ_NONE;
				end else begin
					res_n.rseq = next_seq;
					if ($signed(wrap_seq) > $signed(gate_q)) begin
						res_n.status = STAT_REFUSED;
						stall_inc    = (stall_q != STALL_MAX);
						res_n.stall  = stall_inc ? stall_q + STALL_W'(1) : stall_q;
					end else begin
						mem_we    = 1'b1;
						cursor_we = 1'b1;
					end
				end
			end
			OP_QUERY: begin
				res_n.rseq = avail;
				if ($signed(avail) < $signed(cmd_q.seq)) begin
					res_n.status = STAT_NOT_AVAIL;
				end
			end
			OP_READ: begin
				res_n.data = PAYLOAD_W'(rd_data_q);
			end
			OP_COMMIT: begin
				pos_we = 1'b1;
			end
			default: begin
				res_n.status = STAT_DONE;
			end
		endcase
	end

	// Sequencer: pop, prepare (gate seed and memory read), scan the consumer
	// positions for a write, then execute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					idx_q   <= '0;
					state_q <= (cmd_q.op == OP_WRITE) ? S_SCAN : S_EXEC;
				end
				S_SCAN: begin
					if (idx_q == CONS_W'(MAX_CONSUMERS - 1)) begin
						state_q <= S_EXEC;
					end else begin
						idx_q <= idx_q + CONS_W'(1);
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == S_PREP) begin
			gate_q <= cursor_q;
		end else if (state_q == S_SCAN) begin
			if ((ACT_W'(idx_q) < active_n) && ($signed(pos_q[idx_q]) < $signed(gate_q))) begin
				gate_q <= pos_q[idx_q];
			end
		end
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q      <= SEQ_NONE;
			stall_q       <= '0;
			cons_in_use_q <= CFG_N_W'(1);
			chained_q     <= 1'b0;
			for (int i = 0; i < MAX_CONSUMERS; i++) begin
				pos_q[i] <= SEQ_NONE;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CONSUMERS: cons_in_use_q <= cfg_wdata[CFG_N_W-1:0];
					CFG_CHAINED:   chained_q     <= cfg_wdata[0];
					default:       chained_q     <= chained_q;
				endcase
			end
			if (exec_fire && cursor_we) begin
				cursor_q <= next_seq;
			end
			if (exec_fire && stall_inc) begin
				stall_q <= stall_q + STALL_W'(1);
			end
			if (exec_fire && pos_we) begin
				pos_q[cmd_q.who] <= cmd_q.seq;
			end
		end
	end

	// Ring memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (exec_fire && mem_we) begin
			ring_q[next_seq[SLOT_W-1:0]] <= cmd_q.payload;
		end
		if (state_q == S_PREP) begin
			rd_data_q <= ring_q[cmd_q.slot];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			out_q <= res_n;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> rtl/core/gated_broadcast_ring_buffer.sv
// ----------------------------------------------------------------------------
// gated_broadcast_ring_buffer: single-producer broadcast ring
// Top level: input stage, command queue and execution side.
// ----------------------------------------------------------------------------
// One producer writes entries into a ring of 4096 slots of 64 bits, and every
// consumer reads every entry. A write transaction claims the sequence after
// the cursor and stores its payload, unless that would overwrite an entry
// that the slowest active consumer has not yet passed; it is then refused
// with status 1 and counted in a saturating stall counter. A write is also
// refused, with result sequence -1 and no stall counted, once the cursor has
// reached the largest positive 48-bit sequence. A query transaction returns
// the highest sequence that a consumer may see (the cursor, or in chained
// mode the position of the previous consumer) and status 2 if that is below
// the requested sequence. A read returns the entry at a sequence without any
// check, and a commit sets a consumer's position. Every input transaction
// gives exactly one result transaction. The input stage registers and decodes
// each transaction and places it into a two-entry command queue; the
// execution side then takes one command at a time. After leaving the queue,
// a command is taken, the gate is seeded and the ring memory is read through
// its registered port, the four consumer positions are scanned for the
// slowest one (writes only), and the command executes into the output
// register once that register is free or its result is being taken. The
// output register lets the next command start while a result waits to be
// taken. Configuration is written through cfg_we, cfg_index and cfg_wdata;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Index 0 is the number of active consumers (0
// acts as 1, above 4 acts as 4), index 1 the chained bit. Entries of the
// ring read before they were ever written return undefined data.
// ----------------------------------------------------------------------------
module gated_broadcast_ring_buffer import gbrb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata, from bit 0: operation[1:0], consumer[3:2], sequence_req[51:4],
	// payload[115:52], zero fill[119:116].
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata, from bit 0: status[1:0], result_sequence[49:2], data[113:50],
	// stall_total[145:114], zero fill[151:146].
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t q_cmd;
	logic pop;
	res_t res;

	gbrb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	gbrb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop)
	);

	gbrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = OUT_TDATA_W'({res.stall, res.data, res.rseq, res.status});

	// The input stage never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("command pushed into a full queue");

	// The execution side never takes a command from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !q_valid))
		else $error("command popped from an empty queue");

	// The stall total never decreases from one result to the next.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid || (res.stall >= $past(res.stall)))
		else $error("stall total decreased");

	// Only a read result carries data, so a refused or pending status has none.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.status == STAT_REFUSED || res.status == STAT_NOT_AVAIL)
		|-> res.data == '0)
		else $error("data returned with a non-done status");

endmodule
